/* hdl/rmq_pkg.sv */
// Shared constants, widths and payload types for the rotation matrix to quaternion core.
// No dependencies; every other file of the block imports this package.
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DATA_W    = 16;
	// Largest positive radicand is one plus three full-scale diagonal magnitudes.
	localparam int RAD_W     = $clog2((1 << FRAC_BITS) + 98304);
	localparam int RS_W      = RAD_W + 2;
	localparam int SQ_W      = (RAD_W + FRAC_BITS + 3) / 2;
	localparam int ROOT_IN_W = 2 * SQ_W;
	localparam int NUM_W     = DATA_W + 1;
	localparam int DVD_W     = NUM_W + FRAC_BITS;
	localparam int LANES     = 3;

	typedef enum logic [1:0] {
		CASE_TRACE = 2'd0,
		CASE_X     = 2'd1,
		CASE_Y     = 2'd2,
		CASE_Z     = 2'd3
	} pcase_t;

	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [NUM_W-1:0] mag_t;
	typedef logic [DVD_W-1:0] quo_t;

	typedef struct packed {
		pcase_t pcase;
		logic   degen;
		num_t   na;
		num_t   nb;
		num_t   nc;
	} sq_pay_t;

	typedef struct packed {
		pcase_t              pcase;
		logic                degen;
		logic [DATA_W-1:0]   piv;
		logic [LANES-1:0]    neg;
	} dv_pay_t;

endpackage

/* hdl/rmq_front.sv */
// Front stage: trace test, pivot choice, radicand and the three numerators.
// Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic signed [DATA_W-1:0] m00,
	input  logic signed [DATA_W-1:0] m01,
	input  logic signed [DATA_W-1:0] m02,
	input  logic signed [DATA_W-1:0] m10,
	input  logic signed [DATA_W-1:0] m11,
	input  logic signed [DATA_W-1:0] m12,
	input  logic signed [DATA_W-1:0] m20,
	input  logic signed [DATA_W-1:0] m21,
	input  logic signed [DATA_W-1:0] m22,
	output logic                     valid_s1,
	output logic [RAD_W-1:0]         rad_s1,
	output sq_pay_t                  pay_s1
);

	localparam logic signed [RS_W-1:0] ONE =
		{{(RS_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	logic signed [RS_W-1:0] e00, e11, e22, trace, rad;
	num_t    d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
	pcase_t  pcase;
	logic    degen;
	sq_pay_t pay;
	logic [RAD_W-1:0] rad_u;

	assign e00 = RS_W'(m00);
	assign e11 = RS_W'(m11);
	assign e22 = RS_W'(m22);

	assign d21_12 = NUM_W'(m21) - NUM_W'(m12);
	assign d02_20 = NUM_W'(m02) - NUM_W'(m20);
	assign d10_01 = NUM_W'(m10) - NUM_W'(m01);
	assign s01_10 = NUM_W'(m01) + NUM_W'(m10);
	assign s02_20 = NUM_W'(m02) + NUM_W'(m20);
	assign s12_21 = NUM_W'(m12) + NUM_W'(m21);

	always_comb begin
		trace = e00 + e11 + e22;
		priority if (trace > 0) begin
			pcase = CASE_TRACE;
			rad   = ONE + trace;
		end else if (m00 > m11 && m00 > m22) begin
			pcase = CASE_X;
			rad   = ONE + e00 - e11 - e22;
		end else if (m11 > m22) begin
			pcase = CASE_Y;
			rad   = ONE + e11 - e00 - e22;
		end else begin
			pcase = CASE_Z;
			rad   = ONE + e22 - e00 - e11;
		end
		degen = rad[RS_W-1] || (rad == '0);
		// A degenerate item still runs through the datapath with a harmless radicand.
		rad_u = degen ? RAD_W'(1) : rad[RAD_W-1:0];
		pay.pcase = pcase;
		pay.degen = degen;
		unique case (pcase)
			CASE_TRACE: begin
				pay.na = d21_12;
				pay.nb = d02_20;
				pay.nc = d10_01;
			end
			CASE_X: begin
				pay.na = s01_10;
				pay.nb = s02_20;
				pay.nc = d21_12;
			end
			CASE_Y: begin
				pay.na = s01_10;
				pay.nb = s12_21;
				pay.nc = d02_20;
			end
			default: begin
				pay.na = s02_20;
				pay.nb = s12_21;
				pay.nc = d10_01;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= rad_u;
			pay_s1 <= pay;
		end
	end

endmodule

/* hdl/rmq_sqrt.sv */
// Pipelined integer square root, one result bit per stage, payload carried alongside.
// Depends on rmq_pkg.
module rmq_sqrt import rmq_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_in,
	input  logic [RAD_W-1:0] rad,
	input  sq_pay_t          pay_in,
	output logic             valid_out,
	output logic [SQ_W-1:0]  root_out,
	output sq_pay_t          pay_out
);

	logic [SQ_W+1:0]      rem_s  [SQ_W];
	logic [SQ_W-1:0]      root_s [SQ_W];
	logic [ROOT_IN_W-1:0] v_s    [SQ_W];
	logic                 vld_s  [SQ_W];
	sq_pay_t              pay_s  [SQ_W];

	logic [SQ_W+1:0]      cur_rem  [SQ_W];
	logic [SQ_W-1:0]      cur_root [SQ_W];
	logic [ROOT_IN_W-1:0] cur_v    [SQ_W];
	logic                 cur_vld  [SQ_W];
	sq_pay_t              cur_pay  [SQ_W];

	for (genvar k = 0; k < SQ_W; k++) begin : g_stage
		logic [SQ_W+1:0] rem_sh, trial;
		logic            take;

		if (k == 0) begin : g_src_in
			assign cur_rem[k]  = '0;
			assign cur_root[k] = '0;
			assign cur_v[k]    = ROOT_IN_W'({rad, {(FRAC_BITS+2){1'b0}}});
			assign cur_vld[k]  = valid_in;
			assign cur_pay[k]  = pay_in;
		end else begin : g_src_reg
			assign cur_rem[k]  = rem_s[k-1];
			assign cur_root[k] = root_s[k-1];
			assign cur_v[k]    = v_s[k-1];
			assign cur_vld[k]  = vld_s[k-1];
			assign cur_pay[k]  = pay_s[k-1];
		end

		// The remainder never exceeds twice the partial root, so its low bits suffice.
		assign rem_sh = {cur_rem[k][SQ_W-1:0], cur_v[k][ROOT_IN_W-1 -: 2]};
		assign trial  = {cur_root[k], 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_sh - trial : rem_sh;
				root_s[k] <= {cur_root[k][SQ_W-2:0], take};
				v_s[k]    <= {cur_v[k][ROOT_IN_W-3:0], 2'b00};
				pay_s[k]  <= cur_pay[k];
			end
		end
	end

	assign valid_out = vld_s[SQ_W-1];
	assign root_out  = root_s[SQ_W-1];
	assign pay_out   = pay_s[SQ_W-1];

endmodule

/* hdl/rmq_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on rmq_pkg.
module rmq_div import rmq_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_in,
	input  logic [SQ_W-1:0] divisor,
	input  mag_t            mag_in [LANES],
	input  dv_pay_t         pay_in,
	output logic            valid_out,
	output quo_t            quo_out [LANES],
	output dv_pay_t         pay_out
);

	logic [SQ_W-1:0] dsr_s [DVD_W];
	logic [SQ_W:0]   rem_s [DVD_W][LANES];
	quo_t            dq_s  [DVD_W][LANES];
	logic            vld_s [DVD_W];
	dv_pay_t         pay_s [DVD_W];

	logic [SQ_W-1:0] cur_dsr [DVD_W];
	logic [SQ_W:0]   cur_rem [DVD_W][LANES];
	quo_t            cur_dq  [DVD_W][LANES];
	logic            cur_vld [DVD_W];
	dv_pay_t         cur_pay [DVD_W];

	for (genvar k = 0; k < DVD_W; k++) begin : g_stage
		if (k == 0) begin : g_src_in
			assign cur_dsr[k] = divisor;
			assign cur_vld[k] = valid_in;
			assign cur_pay[k] = pay_in;
			for (genvar l = 0; l < LANES; l++) begin : g_lane_in
				assign cur_rem[k][l] = '0;
				assign cur_dq[k][l]  = {mag_in[l], {FRAC_BITS{1'b0}}};
			end
		end else begin : g_src_reg
			assign cur_dsr[k] = dsr_s[k-1];
			assign cur_vld[k] = vld_s[k-1];
			assign cur_pay[k] = pay_s[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_lane_reg
				assign cur_rem[k][l] = rem_s[k-1][l];
				assign cur_dq[k][l]  = dq_s[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= cur_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dsr_s[k] <= cur_dsr[k];
				pay_s[k] <= cur_pay[k];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [SQ_W:0] rem_sh;
			logic          take;

			// Dividend bits shift out the top while quotient bits enter at the bottom.
			assign rem_sh = {cur_rem[k][l][SQ_W-1:0], cur_dq[k][l][DVD_W-1]};
			assign take   = rem_sh >= {1'b0, cur_dsr[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= take ? rem_sh - {1'b0, cur_dsr[k]} : rem_sh;
					dq_s[k][l]  <= {cur_dq[k][l][DVD_W-2:0], take};
				end
			end
		end
	end

	assign valid_out = vld_s[DVD_W-1];
	assign pay_out   = pay_s[DVD_W-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo_out[l] = dq_s[DVD_W-1][l];
	end

endmodule

/* hdl/rotation_matrix_to_quaternion_core.sv */
// Top level of the rotation matrix to quaternion core: front stage, square root, dividers
// and the output register. Depends on rmq_pkg, rmq_front, rmq_sqrt and rmq_div.
//
// The input channel takes the nine elements of a 3x3 rotation matrix (signed Q1.14) on
// in_valid/in_stall; the output channel delivers quat_x/y/z/w, pivot_case and degenerate
// on out_valid/out_stall. A transaction completes on a clock edge where valid is high and
// stall is low.
// The pipeline is one front stage, one stage per root bit of the square root, one stage per
// quotient bit of the three dividers, and the output register. One matrix is accepted per
// cycle while in_stall is low.
// All stages advance together. When the output holds a result and out_stall is high the
// whole pipeline freezes and in_stall is raised in the same cycle; nothing is dropped.
// An empty output register never stalls the pipeline.
// Reset clears all valid bits; there is no other state, so the block is ready for input
// right after reset is released.
// A matrix whose radicand is not positive yields zero components and degenerate set.
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] m00,
	input  logic signed [DATA_W-1:0] m01,
	input  logic signed [DATA_W-1:0] m02,
	input  logic signed [DATA_W-1:0] m10,
	input  logic signed [DATA_W-1:0] m11,
	input  logic signed [DATA_W-1:0] m12,
	input  logic signed [DATA_W-1:0] m20,
	input  logic signed [DATA_W-1:0] m21,
	input  logic signed [DATA_W-1:0] m22,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] quat_x,
	output logic signed [DATA_W-1:0] quat_y,
	output logic signed [DATA_W-1:0] quat_z,
	output logic signed [DATA_W-1:0] quat_w,
	output logic [1:0]               pivot_case,
	output logic                     degenerate
);

	logic             en;
	logic             valid_s1, sq_valid, dv_valid;
	logic [RAD_W-1:0] rad_s1;
	sq_pay_t          pay_s1, sq_pay;
	logic [SQ_W-1:0]  root;
	mag_t             mag [LANES];
	num_t             num [LANES];
	dv_pay_t          dv_in, dv_pay;
	quo_t             quo [LANES];
	logic [DATA_W-1:0] comp [LANES];
	logic [DATA_W-1:0] qx, qy, qz, qw;
	logic              out_valid_q;
	logic [DATA_W-1:0] quat_x_q, quat_y_q, quat_z_q, quat_w_q;
	pcase_t            pcase_q;
	logic              degen_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	rmq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.m00      (m00),
		.m01      (m01),
		.m02      (m02),
		.m10      (m10),
		.m11      (m11),
		.m12      (m12),
		.m20      (m20),
		.m21      (m21),
		.m22      (m22),
		.valid_s1 (valid_s1),
		.rad_s1   (rad_s1),
		.pay_s1   (pay_s1)
	);

	rmq_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (valid_s1),
		.rad       (rad_s1),
		.pay_in    (pay_s1),
		.valid_out (sq_valid),
		.root_out  (root),
		.pay_out   (sq_pay)
	);

	assign num[0] = sq_pay.na;
	assign num[1] = sq_pay.nb;
	assign num[2] = sq_pay.nc;

	always_comb begin
		dv_in.pcase = sq_pay.pcase;
		dv_in.degen = sq_pay.degen;
		if (32'(root >> 2) > 32'd32767) begin
			dv_in.piv = 16'h7fff;
		end else begin
			dv_in.piv = DATA_W'(root >> 2);
		end
		for (int l = 0; l < LANES; l++) begin
			dv_in.neg[l] = num[l][NUM_W-1];
			mag[l]       = num[l][NUM_W-1] ? mag_t'(-num[l]) : mag_t'(num[l]);
		end
	end

	rmq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (sq_valid),
		.divisor   (root),
		.mag_in    (mag),
		.pay_in    (dv_in),
		.valid_out (dv_valid),
		.quo_out   (quo),
		.pay_out   (dv_pay)
	);

	// Signed saturation of each quotient: negative results may reach -32768.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (dv_pay.neg[l]) begin
				if (quo[l] > DVD_W'(32768)) begin
					comp[l] = 16'h8000;
				end else begin
					comp[l] = DATA_W'(-quo[l]);
				end
			end else begin
				if (quo[l] > DVD_W'(32767)) begin
					comp[l] = 16'h7fff;
				end else begin
					comp[l] = DATA_W'(quo[l]);
				end
			end
		end
		unique case (dv_pay.pcase)
			CASE_TRACE: begin
				qx = comp[0];
				qy = comp[1];
				qz = comp[2];
				qw = dv_pay.piv;
			end
			CASE_X: begin
				qx = dv_pay.piv;
				qy = comp[0];
				qz = comp[1];
				qw = comp[2];
			end
			CASE_Y: begin
				qx = comp[0];
				qy = dv_pay.piv;
				qz = comp[1];
				qw = comp[2];
			end
			default: begin
				qx = comp[0];
				qy = comp[1];
				qz = dv_pay.piv;
				qw = comp[2];
			end
		endcase
		if (dv_pay.degen) begin
			qx = '0;
			qy = '0;
			qz = '0;
			qw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_x_q <= qx;
			quat_y_q <= qy;
			quat_z_q <= qz;
			quat_w_q <= qw;
			pcase_q  <= dv_pay.pcase;
			degen_q  <= dv_pay.degen;
		end
	end

	assign out_valid  = out_valid_q;
	assign quat_x     = quat_x_q;
	assign quat_y     = quat_y_q;
	assign quat_z     = quat_z_q;
	assign quat_w     = quat_w_q;
	assign pivot_case = pcase_q;
	assign degenerate = degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
			quat_x == '0 && quat_y == '0 && quat_z == '0 && quat_w == '0)
		else $error("degenerate result carries nonzero components");

	a_trace_w_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate && pivot_case == CASE_TRACE |-> !quat_w[DATA_W-1])
		else $error("trace case produced a negative scalar component");

	a_pivot_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !degenerate && pivot_case != CASE_TRACE |->
			(pivot_case == CASE_X && !quat_x[DATA_W-1]) ||
			(pivot_case == CASE_Y && !quat_y[DATA_W-1]) ||
			(pivot_case == CASE_Z && !quat_z[DATA_W-1]))
		else $error("pivot component is negative");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> out_valid)
		else $error("a stalled pipeline lost its output transaction");

endmodule

/* tb/tb_rotation_matrix_to_quaternion_core.sv */
// Self-checking testbench for rotation_matrix_to_quaternion_core: directed matrices, then
// random ones under varied idle and stall patterns, checked against a behavioral predictor.
// Depends on rmq_pkg and the core RTL.
module tb_rotation_matrix_to_quaternion_core;
	import rmq_pkg::*;

	localparam int NUM_RANDOM = 1250;
	localparam int LATENCY    = 50;
	localparam int LIMIT      = 400000;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		pcase_t             pc;
		logic               degen;
	} quat_res_t;

	typedef struct {
		logic signed [15:0] m [9];
		logic               has_golden;
		quat_res_t          golden;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	logic signed [15:0] mat [9];
	logic in_stall, out_valid, degenerate;
	logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
	logic [1:0] pivot_case;

	quat_res_t pending_quats[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;

	rotation_matrix_to_quaternion_core u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.m00(mat[0]), .m01(mat[1]), .m02(mat[2]), .m10(mat[3]), .m11(mat[4]),
		.m12(mat[5]), .m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
		.out_valid(out_valid), .out_stall(out_stall), .quat_x(quat_x), .quat_y(quat_y),
		.quat_z(quat_z), .quat_w(quat_w), .pivot_case(pivot_case), .degenerate(degenerate)
	);

	initial begin
		for (int i = 0; i < 9; i++) mat[i] = '0;
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else
				root >>= 1;
			bitv >>= 2;
		end
		return root;
	endfunction

	// Quotient truncates toward zero and saturates to 16 bits.
	function automatic logic signed [15:0] scaled_div(longint num, longint unsigned s);
		longint unsigned mag, q;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag << FRAC_BITS) / s;
		if (num < 0) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
		return (q > 32767) ? 16'sd32767 : 16'(q);
	endfunction

	function automatic quat_res_t predict_quat(logic signed [15:0] m [9]);
		quat_res_t r;
		longint a [9];
		longint one, tr, rad, piv;
		longint unsigned s;
		for (int i = 0; i < 9; i++) a[i] = m[i];
		one = longint'(1) << FRAC_BITS;
		tr = a[0] + a[4] + a[8];
		r = '{x: 0, y: 0, z: 0, w: 0, pc: CASE_TRACE, degen: 1'b0};
		if (tr > 0) begin
			r.pc = CASE_TRACE; rad = one + tr;
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			r.pc = CASE_X; rad = one + a[0] - a[4] - a[8];
		end else if (a[4] > a[8]) begin
			r.pc = CASE_Y; rad = one + a[4] - a[0] - a[8];
		end else begin
			r.pc = CASE_Z; rad = one + a[8] - a[0] - a[4];
		end
		if (rad <= 0) begin
			r.degen = 1'b1;
			return r;
		end
		s = int_sqrt(longint'(rad) << (FRAC_BITS + 2));
		piv = s >> 2;
		if (piv > 32767) piv = 32767;
		case (r.pc)
			CASE_TRACE: begin
				r.w = 16'(piv);
				r.x = scaled_div(a[7] - a[5], s);
				r.y = scaled_div(a[2] - a[6], s);
				r.z = scaled_div(a[3] - a[1], s);
			end
			CASE_X: begin
				r.x = 16'(piv);
				r.y = scaled_div(a[1] + a[3], s);
				r.z = scaled_div(a[2] + a[6], s);
				r.w = scaled_div(a[7] - a[5], s);
			end
			CASE_Y: begin
				r.y = 16'(piv);
				r.x = scaled_div(a[1] + a[3], s);
				r.z = scaled_div(a[5] + a[7], s);
				r.w = scaled_div(a[2] - a[6], s);
			end
			default: begin
				r.z = 16'(piv);
				r.x = scaled_div(a[2] + a[6], s);
				r.y = scaled_div(a[5] + a[7], s);
				r.w = scaled_div(a[3] - a[1], s);
			end
		endcase
		return r;
	endfunction

	// Receiver: random stall, plus a long hold-off counted here when requested.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		quat_res_t exp_q;
		cycles <= cycles + 1;
		if (out_valid && !out_stall && arst_n) begin
			if (pending_quats.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
			end else begin
				exp_q = pending_quats.pop_front();
				if (quat_x !== exp_q.x || quat_y !== exp_q.y || quat_z !== exp_q.z ||
				    quat_w !== exp_q.w || pivot_case !== exp_q.pc ||
				    degenerate !== exp_q.degen) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp x%0d y%0d z%0d w%0d c%0d d%0d got x%0d y%0d z%0d w%0d c%0d d%0d",
							exp_q.x, exp_q.y, exp_q.z, exp_q.w, exp_q.pc, exp_q.degen,
							quat_x, quat_y, quat_z, quat_w, pivot_case, degenerate);
				end
			end
		end
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Presents one matrix and waits until it is accepted; expectations go in on acceptance.
	task automatic send_matrix(logic signed [15:0] m [9], quat_res_t golden, bit has_golden);
		quat_res_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		p = predict_quat(m);
		if (has_golden && p != golden) begin
			errors++;
			if (errors <= 10) $display("directed row disagrees with predictor");
		end
		for (int i = 0; i < 9; i++) mat[i] <= m[i];
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pending_quats.push_back(p);
		@(negedge clk);
	endtask

	task automatic drain_quats();
		in_valid <= 1'b0;
		while (pending_quats.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(5))
			0: return 16'($urandom);
			1: return 16'sd16384;
			2: return -16'sd16384;
			default: return 16'($signed($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// Builds an exact rotation from a random unit quaternion, then adds a little noise.
	task automatic rand_rotation(output logic signed [15:0] m [9]);
		real qx, qy, qz, qw, n;
		real r [9];
		qx = $itor($signed($urandom_range(2000))) - 1000.0;
		qy = $itor($signed($urandom_range(2000))) - 1000.0;
		qz = $itor($signed($urandom_range(2000))) - 1000.0;
		qw = $itor($signed($urandom_range(2000))) - 1000.0;
		n = $sqrt(qx*qx + qy*qy + qz*qz + qw*qw) + 1e-9;
		qx /= n; qy /= n; qz /= n; qw /= n;
		r[0] = 1 - 2*(qy*qy + qz*qz); r[1] = 2*(qx*qy - qz*qw); r[2] = 2*(qx*qz + qy*qw);
		r[3] = 2*(qx*qy + qz*qw); r[4] = 1 - 2*(qx*qx + qz*qz); r[5] = 2*(qy*qz - qx*qw);
		r[6] = 2*(qx*qz - qy*qw); r[7] = 2*(qy*qz + qx*qw); r[8] = 1 - 2*(qx*qx + qy*qy);
		for (int i = 0; i < 9; i++)
			m[i] = 16'($rtoi(r[i] * 16384.0) + $signed($urandom_range(6)) - 3);
	endtask

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		logic signed [15:0] m [9];
		quat_res_t none;
		int phase_idle [4] = '{0, 47, 0, 35};
		int phase_stall [4] = '{0, 0, 47, 35};
		none = '{x: 0, y: 0, z: 0, w: 0, pc: CASE_TRACE, degen: 1'b0};

		// Identity: trace case, w is exactly one.
		row.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
		row.has_golden = 1; row.golden = '{x: 0, y: 0, z: 0, w: 16384, pc: CASE_TRACE, degen: 0};
		rows.push_back(row);
		// Half-turns about each axis select each pivot with a unit component.
		row.m = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384};
		row.golden = '{x: 16384, y: 0, z: 0, w: 0, pc: CASE_X, degen: 0};
		rows.push_back(row);
		row.m = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384};
		row.golden = '{x: 0, y: 16384, z: 0, w: 0, pc: CASE_Y, degen: 0};
		rows.push_back(row);
		row.m = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384};
		row.golden = '{x: 0, y: 0, z: 16384, w: 0, pc: CASE_Z, degen: 0};
		rows.push_back(row);
		// All-zero matrix: trace is zero, ties fall through to the m22 pivot.
		row.m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		row.golden = '{x: 0, y: 0, z: 8192, w: 0, pc: CASE_Z, degen: 0};
		rows.push_back(row);
		row.has_golden = 0;
		// Full-scale mixed diagonals; the trace stays positive.
		row.m = '{-32768, 0, 0, 0, 32767, 0, 0, 0, 32767};
		rows.push_back(row);
		row.m = '{32767, 0, 0, 0, 32767, 0, 0, 0, -32768};
		rows.push_back(row);
		// Extremes to force saturation and big numerators, checked by the predictor.
		row.m = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767};
		rows.push_back(row);
		row.m = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
		rows.push_back(row);
		row.m = '{1, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
		rows.push_back(row);
		row.m = '{-16384, 32767, 32767, 32767, -16384, -32768, 32767, 32767, -16384};
		rows.push_back(row);
		row.m = '{-16384, 32767, -32768, 32767, 16383, 32767, -32768, 32767, 0};
		rows.push_back(row);
		row.m = '{-21845, 100, -200, 300, -21845, 400, -500, 600, -21845};
		rows.push_back(row);
		row.m = '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
		          16'hAAAA, 16'h5555};
		rows.push_back(row);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_matrix(rows[i].m, rows[i].golden, rows[i].has_golden);
		drain_quats();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			for (int k = 0; k < NUM_RANDOM / 4; k++) begin
				if (ph == 1 && k == 100) hold_off = 200;
				if ($urandom_range(99) < 70) rand_rotation(m);
				else for (int i = 0; i < 9; i++) m[i] = rand_elem();
				send_matrix(m, none, 0);
			end
			// The sender waits here until every expected result has arrived.
			drain_quats();
		end

		recv_stall_pct = 0;
		repeat (2 * LATENCY) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
hdl/rmq_pkg.sv
hdl/rmq_front.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion_core.sv
tb/tb_rotation_matrix_to_quaternion_core.sv
